@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/llx_pkg.sv @@
`timescale 1ns / 1ps

package llx_pkg;

  localparam int CODE_W   = 16;
  localparam int SPAN_W   = 5;
  localparam int SYM_W    = 8;
  localparam int KW_COUNT = 23;
  localparam int KW_MAXLEN = 17;

  localparam logic [CODE_W-1:0] CH_BSL     = 16'h005C;
  localparam logic [CODE_W-1:0] CH_DOLLAR  = 16'h0024;
  localparam logic [CODE_W-1:0] CH_PERCENT = 16'h0025;
  localparam logic [CODE_W-1:0] CH_LBRK    = 16'h005B;
  localparam logic [CODE_W-1:0] CH_RBRK    = 16'h005D;
  localparam logic [CODE_W-1:0] CH_LBRACE  = 16'h007B;
  localparam logic [CODE_W-1:0] CH_RBRACE  = 16'h007D;
  localparam logic [CODE_W-1:0] CH_LPAR    = 16'h0028;
  localparam logic [CODE_W-1:0] CH_RPAR    = 16'h0029;
  localparam logic [CODE_W-1:0] CH_SPACE   = 16'h0020;
  localparam logic [CODE_W-1:0] CH_TILDE   = 16'h007E;
  localparam logic [CODE_W-1:0] CH_COMMA   = 16'h002C;
  localparam logic [CODE_W-1:0] CH_SEMI    = 16'h003B;
  localparam logic [CODE_W-1:0] CH_APOS    = 16'h0027;
  localparam logic [CODE_W-1:0] CH_QUOTE   = 16'h0022;
  localparam logic [CODE_W-1:0] CH_GRAVE   = 16'h0060;
  localparam logic [CODE_W-1:0] CH_CARET   = 16'h005E;

  localparam int KW_LEN [KW_COUNT] = '{
    8, 11, 14, 8, 5, 10, 13, 9, 12, 15, 9, 6, 11, 14, 6, 16, 16, 17, 17, 8, 6, 6, 4
  };

  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_COUNT] = '{
    "section{", "subsection{", "subsubsection{", "chapter{", "part{",
    "paragraph{", "subparagraph{", "section*{", "subsection*{",
    "subsubsection*{", "chapter*{", "part*{", "paragraph*{",
    "subparagraph*{", "label{", "includegraphics{", "includegraphics[",
    "includegraphics*{", "includegraphics*[", "include{", "input{",
    "begin{", "end{"
  };

  typedef enum logic [1:0] {
    CLS_STD     = 2'd0,
    CLS_COMMENT = 2'd1,
    CLS_MATH    = 2'd2,
    CLS_CMD     = 2'd3
  } llx_class_e;

  typedef struct packed {
    logic             line_start;
    logic             is_bsl;
    logic             is_dollar;
    logic             is_percent;
    logic             is_space;
    logic             is_bracket;
    logic             is_punct;
    logic             nx_lbrk;
    logic             nx_rbrk;
    logic             nx_dollar;
    logic [SYM_W-1:0] kw_sym;
  } llx_item_t;

  function automatic logic [SYM_W-1:0] kw_char(input int k, input int i);
    logic [SYM_W-1:0] ch;
    ch = '0;
    if (i < KW_LEN[k]) begin
      ch = KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8];
    end
    return ch;
  endfunction

endpackage

@@ rtl/core/latex_char_class_lexer.sv @@
`timescale 1ns / 1ps

// Highlight lexer for LaTeX text: one UTF-16 code unit per word, with a one-unit
// lookahead, gives the character's class (standard, comment, math, command), a
// keyword recolor request for the span up to and including a bracket that closes a
// command name, and the mode carried to the next line. A character is taken every
// cycle while the queue has room and the output is not stalled; its result is
// registered (the word lands in a two-entry queue that feeds the lexer, whose
// result lands in an output register). The rate is set by the lexer state loop in
// the back end, which updates the mode and the keyword match vector of all end
// positions of all keywords together for each character.
module latex_char_class_lexer #(
  parameter int NAME_DEPTH = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [llx_pkg::CODE_W-1:0]  char_code_i,
  input  logic [llx_pkg::CODE_W-1:0]  next_code_i,
  input  logic                        next_valid_i,
  input  logic                        line_start_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  char_class_o,
  output logic                        keyword_hit_o,
  output logic [llx_pkg::SPAN_W-1:0]  keyword_span_o,
  output logic                        line_mode_o
);
  import llx_pkg::*;

  llx_item_t  front_item;
  llx_item_t  head_item;
  logic       push;
  logic       full;
  logic       pop;
  logic       head_valid;
  llx_class_e cls;

  llx_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .next_code_i  (next_code_i),
    .next_valid_i (next_valid_i),
    .line_start_i (line_start_i),
    .queue_full_i (full),
    .push_o       (push),
    .item_o       (front_item)
  );

  llx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  llx_back #(
    .NAME_DEPTH (NAME_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (head_valid),
    .item_i       (head_item),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .cls_o        (cls),
    .hit_o        (keyword_hit_o),
    .span_o       (keyword_span_o),
    .line_mode_o  (line_mode_o)
  );

  assign char_class_o = cls;

endmodule

@@ rtl/core/llx_front.sv @@
`timescale 1ns / 1ps

module llx_front (
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [llx_pkg::CODE_W-1:0]      char_code_i,
  input  logic [llx_pkg::CODE_W-1:0]      next_code_i,
  input  logic                            next_valid_i,
  input  logic                            line_start_i,
  input  logic                            queue_full_i,
  output logic                            push_o,
  output llx_pkg::llx_item_t              item_o
);
  import llx_pkg::*;

  logic [CODE_W-1:0] c;
  logic [CODE_W-1:0] nx;

  assign c          = char_code_i;
  assign nx         = next_code_i;
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    item_o.line_start = line_start_i;
    item_o.is_bsl     = (c == CH_BSL);
    item_o.is_dollar  = (c == CH_DOLLAR);
    item_o.is_percent = (c == CH_PERCENT);
    item_o.is_space   = (c == CH_SPACE);
    item_o.is_bracket = (c == CH_LPAR) || (c == CH_LBRK) || (c == CH_LBRACE) ||
                        (c == CH_RPAR) || (c == CH_RBRK) || (c == CH_RBRACE);
    item_o.is_punct   = (c == CH_BSL) || (c == CH_COMMA) || (c == CH_SEMI) ||
                        (c == CH_APOS) || (c == CH_QUOTE) || (c == CH_GRAVE) ||
                        (c == CH_CARET) || (c == CH_TILDE);
    item_o.nx_lbrk    = next_valid_i && (nx == CH_LBRK);
    item_o.nx_rbrk    = next_valid_i && (nx == CH_RBRK);
    item_o.nx_dollar  = next_valid_i && (nx == CH_DOLLAR);
    // units above 8 bits map to zero, which no keyword holds
    item_o.kw_sym     = (c[CODE_W-1:SYM_W] == '0) ? c[SYM_W-1:0] : '0;
  end

endmodule

@@ rtl/core/llx_queue.sv @@
`timescale 1ns / 1ps

module llx_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  llx_pkg::llx_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output llx_pkg::llx_item_t item_o
);
  import llx_pkg::*;

  llx_item_t head_q;
  llx_item_t tail_q;
  logic      head_vld_q;
  logic      tail_vld_q;

  assign full_o  = tail_vld_q;
  assign valid_o = head_vld_q;
  assign item_o  = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else if (pop_i) begin
      if (tail_vld_q) begin
        head_vld_q <= 1'b1;
        tail_vld_q <= push_i;
      end else begin
        head_vld_q <= push_i;
      end
    end else if (push_i) begin
      if (!head_vld_q) begin
        head_vld_q <= 1'b1;
      end else begin
        tail_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      if (tail_vld_q) begin
        head_q <= tail_q;
        if (push_i) begin
          tail_q <= item_i;
        end
      end else if (push_i) begin
        head_q <= item_i;
      end
    end else if (push_i) begin
      if (!head_vld_q) begin
        head_q <= item_i;
      end else begin
        tail_q <= item_i;
      end
    end
  end

endmodule

@@ rtl/core/llx_back.sv @@
`timescale 1ns / 1ps

module llx_back #(
  parameter int NAME_DEPTH = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       item_valid_i,
  input  llx_pkg::llx_item_t         item_i,
  output logic                       pop_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output llx_pkg::llx_class_e        cls_o,
  output logic                       hit_o,
  output logic [llx_pkg::SPAN_W-1:0] span_o,
  output logic                       line_mode_o
);
  import llx_pkg::*;

  localparam int LEN_W = $clog2(NAME_DEPTH + 1);

  llx_class_e            mode_q, mode_d;
  logic                  skip_q, skip_d;
  logic                  prev_bsl_q, prev_bsl_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic                  ovf_q, ovf_d;
  logic [KW_MAXLEN:0]    match_q [KW_COUNT];
  logic [KW_MAXLEN:0]    match_d [KW_COUNT];
  logic [KW_MAXLEN:0]    match_v [KW_COUNT];

  llx_class_e            cls_d;
  logic                  hit_d;
  logic                  kw_any;

  llx_class_e            cls_q;
  logic                  hit_q;
  logic [SPAN_W-1:0]     span_q;
  logic                  line_mode_q;
  logic                  out_valid_q;

  assign pop_o       = item_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign cls_o       = cls_q;
  assign hit_o       = hit_q;
  assign span_o      = span_q;
  assign line_mode_o = line_mode_q;

  always_comb begin
    mode_d     = mode_q;
    skip_d     = skip_q;
    prev_bsl_d = prev_bsl_q;
    len_d      = len_q;
    ovf_d      = ovf_q;
    match_d    = match_q;
    match_v    = match_q;
    cls_d      = CLS_STD;
    hit_d      = 1'b0;
    kw_any     = 1'b0;

    if (item_i.line_start) begin
      if (mode_d != CLS_MATH) begin
        mode_d = CLS_STD;
      end
      prev_bsl_d = 1'b0;
      skip_d     = 1'b0;
      len_d      = '0;
      ovf_d      = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
        match_d[k] = '1;
      end
    end

    if (skip_d) begin
      skip_d = 1'b0;
      cls_d  = CLS_MATH;
    end else begin
      if (mode_d != CLS_CMD) begin
        len_d = '0;
        ovf_d = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
          match_d[k] = '1;
        end
      end else if (len_d < LEN_W'(NAME_DEPTH)) begin
        // advance every candidate end position by one character
        match_v = match_d;
        for (int k = 0; k < KW_COUNT; k++) begin
          match_d[k][0] = 1'b0;
          for (int e = 0; e < KW_MAXLEN; e++) begin
            match_d[k][e+1] = match_v[k][e] && (kw_char(k, e) == item_i.kw_sym);
          end
        end
        len_d = len_d + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end

      for (int k = 0; k < KW_COUNT; k++) begin
        for (int e = 1; e <= KW_MAXLEN; e++) begin
          if (e <= KW_LEN[k]) begin
            kw_any = kw_any | match_d[k][e];
          end
        end
      end

      case (mode_d)
        CLS_STD: begin
          if (item_i.is_bsl) begin
            if (item_i.nx_lbrk) begin
              cls_d  = CLS_MATH;
              mode_d = CLS_MATH;
              skip_d = 1'b1;
            end else begin
              cls_d  = CLS_CMD;
              mode_d = CLS_CMD;
            end
          end else if (item_i.is_dollar) begin
            cls_d  = CLS_MATH;
            mode_d = CLS_MATH;
            skip_d = item_i.nx_dollar;
          end else if (item_i.is_percent) begin
            cls_d  = CLS_COMMENT;
            mode_d = CLS_COMMENT;
          end else begin
            cls_d  = CLS_STD;
          end
        end
        CLS_COMMENT: begin
          cls_d = CLS_COMMENT;
        end
        CLS_MATH: begin
          cls_d = CLS_MATH;
          if (item_i.is_dollar) begin
            mode_d = CLS_STD;
            skip_d = item_i.nx_dollar;
          end else if (item_i.is_bsl && item_i.nx_rbrk) begin
            mode_d = CLS_STD;
            skip_d = 1'b1;
          end
        end
        default: begin
          if (item_i.is_dollar) begin
            cls_d  = prev_bsl_d ? CLS_CMD : CLS_MATH;
            mode_d = prev_bsl_d ? CLS_STD : CLS_MATH;
          end else if (item_i.is_percent) begin
            cls_d  = prev_bsl_d ? CLS_STD : CLS_COMMENT;
            mode_d = prev_bsl_d ? CLS_STD : CLS_COMMENT;
          end else if (item_i.is_space) begin
            cls_d  = CLS_STD;
            mode_d = CLS_STD;
          end else if (item_i.is_bracket) begin
            cls_d  = CLS_STD;
            mode_d = CLS_STD;
            hit_d  = !ovf_d && (len_d != '0) && kw_any;
          end else if (item_i.is_punct) begin
            cls_d  = CLS_CMD;
            mode_d = prev_bsl_d ? CLS_STD : CLS_CMD;
          end else begin
            cls_d  = CLS_CMD;
          end
        end
      endcase
      prev_bsl_d = item_i.is_bsl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= CLS_STD;
      skip_q      <= 1'b0;
      prev_bsl_q  <= 1'b0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
        match_q[k] <= '1;
      end
    end else begin
      if (pop_o) begin
        mode_q     <= mode_d;
        skip_q     <= skip_d;
        prev_bsl_q <= prev_bsl_d;
        len_q      <= len_d;
        ovf_q      <= ovf_d;
        match_q    <= match_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cls_q       <= cls_d;
      hit_q       <= hit_d;
      span_q      <= hit_d ? len_d[SPAN_W-1:0] : '0;
      line_mode_q <= (mode_d == CLS_MATH);
    end
  end

endmodule

@@ rtl/core/llx_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module llx_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [llx_pkg::CODE_W-1:0]  char_code_i,
  input logic [llx_pkg::CODE_W-1:0]  next_code_i,
  input logic                        next_valid_i,
  input logic                        line_start_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  char_class_o,
  input logic                        keyword_hit_o,
  input logic [llx_pkg::SPAN_W-1:0]  keyword_span_o,
  input logic                        line_mode_o
);
  import llx_pkg::*;

  logic out_stalled;
  logic span_ok;
  logic in_seen;

  assign out_stalled = out_valid_o && out_stall_i;
  assign span_ok     = (keyword_span_o != '0) &&
                       (keyword_span_o <= SPAN_W'(KW_MAXLEN));
  assign in_seen     = in_valid_i && !in_stall_o && (char_code_i == char_code_i) &&
                       (next_code_i == next_code_i) && (next_valid_i == next_valid_i) &&
                       (line_start_i == line_start_i);

  `ASSERT_IMP(a_hit_span, clk_i, rst_ni, out_valid_o && keyword_hit_o, span_ok)
  `ASSERT_IMP(a_no_hit_zero, clk_i, rst_ni, out_valid_o && !keyword_hit_o, keyword_span_o == '0)
  `ASSERT_IMP(a_hit_std, clk_i, rst_ni, out_valid_o && keyword_hit_o, char_class_o == CLS_STD)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stalled, out_valid_o && $stable(char_class_o) && $stable(keyword_hit_o) && $stable(keyword_span_o) && $stable(line_mode_o))
  `ASSERT_NEXT(a_accept_result, clk_i, rst_ni, in_seen && !out_valid_o, out_valid_o || !in_stall_o)

endmodule

bind latex_char_class_lexer llx_checker u_llx_checker (.*);
